// File: sv/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg: shared types for the Huffman code builder
// Sequencer state encoding and the return context of the heap sift routine.
// ----------------------------------------------------------------------------
package hcb_pkg;

  typedef enum logic [20:0] {
    S_LOAD    = 21'h000001,
    S_SD_LD   = 21'h000002,
    S_SD_V    = 21'h000004,
    S_SD_L    = 21'h000008,
    S_SD_R    = 21'h000010,
    S_SD_RC   = 21'h000020,
    S_SD_DEC  = 21'h000040,
    S_MRG     = 21'h000080,
    S_TK0     = 21'h000100,
    S_TK1     = 21'h000200,
    S_TK2     = 21'h000400,
    S_MK      = 21'h000800,
    S_PU_CHK  = 21'h001000,
    S_PU_CMP  = 21'h002000,
    S_ROOT    = 21'h004000,
    S_WK_POP  = 21'h008000,
    S_WK_NODE = 21'h010000,
    S_WK_CAP  = 21'h020000,
    S_WK_OUT  = 21'h040000,
    S_WK_PR   = 21'h080000,
    S_WK_PL   = 21'h100000
  } state_t;

  typedef enum logic [1:0] {
    PH_HEAP,
    PH_TA,
    PH_TB
  } phase_t;

  localparam int CODE_W = 31;
  localparam int LEN_W  = 6;

endpackage

// File: sv/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/huffman_code_builder.sv
// Loading: one symbol per cycle, in_ready high while collecting a set.
// Build: heapify plus n-1 merges, each merge two extract-mins and one insert
//   through the single heap RAM.
// Emit: per tree node walked, pop and read; a leaf is captured and held until
//   out_ready; inner nodes push both children, or drop if stack room is short.
// Reset (rst, synchronous): returns to loading with an empty set; RAMs are
//   not cleared.
// ----------------------------------------------------------------------------
// huffman_code_builder: iterative Huffman code construction
// Collects symbol/frequency pairs, builds a min-heap, merges nodes and walks
// the tree to emit one code per leaf.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 32,
  parameter int FREQ_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  symbol,
  input  logic [15:0] frequency,
  input  logic        final_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  coded_symbol,
  output logic [30:0] code_bits,
  output logic [4:0]  code_length,
  output logic        overflow_flag,
  output logic        last_code
);

  localparam int HAW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int NW  = $clog2(2 * MAX_SYMBOLS);
  localparam int IW  = $clog2(2 * MAX_SYMBOLS + 1) + 1;
  localparam int WW  = FREQ_WIDTH + NW;
  localparam int HEW = NW + WW;
  localparam int SAW = $clog2(MAX_SYMBOLS + 1);
  localparam int SPW = $clog2(MAX_SYMBOLS + 2);
  localparam int SEW = NW + hcb_pkg::CODE_W + hcb_pkg::LEN_W;
  localparam logic [WW-1:0]    FMASK = WW'({FREQ_WIDTH{1'b1}});
  localparam logic [IW-1:0]    MAXI  = IW'(MAX_SYMBOLS);
  localparam logic [SPW:0]     SPLIM = (SPW + 1)'(MAX_SYMBOLS + 1);

  hcb_pkg::state_t state;
  hcb_pkg::phase_t phase;

  logic [IW-1:0]  loaded, n, cnt, idx, hidx, best_i, emitted;
  logic           dropped;
  logic [HEW-1:0] v, best_e, top, a_ent;
  logic [NW-1:0]  next_node, left_n;
  logic [SPW-1:0] sp;
  logic [30:0]    wcode;
  logic [5:0]     wlen;

  // RAM ports
  logic           s_we;
  logic [HAW-1:0] s_waddr, s_raddr;
  logic [7:0]     s_rdata;
  logic           h_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [HEW-1:0] h_wdata, h_rdata;
  logic           c_we;
  logic [NW-1:0]  c_waddr, c_raddr;
  logic [2*NW-1:0] c_wdata, c_rdata;
  logic           k_we;
  logic [SAW-1:0] k_waddr, k_raddr;
  logic [SEW-1:0] k_wdata, k_rdata;

  logic [IW-1:0]  loaded_next, lidx, ridx, pidx;
  logic [WW-1:0]  freq_w;
  logic [NW-1:0]  k_node;
  logic [30:0]    k_code;
  logic [5:0]     k_len;
  logic           k_leaf, k_room;

  assign freq_w  = WW'(frequency) & FMASK;
  assign loaded_next = (loaded < MAXI) ? loaded + IW'(1) : loaded;
  assign lidx    = {idx[IW-2:0], 1'b1};
  assign ridx    = lidx + IW'(1);
  assign pidx    = (idx - IW'(1)) >> 1;
  assign k_node  = k_rdata[SEW-1 -: NW];
  assign k_code  = k_rdata[hcb_pkg::LEN_W +: hcb_pkg::CODE_W];
  assign k_len   = k_rdata[hcb_pkg::LEN_W-1:0];
  assign k_leaf  = IW'(k_node) < n;
  assign k_room  = ({1'b0, sp} + (SPW + 1)'(2)) <= SPLIM;

  assign in_ready  = (state == hcb_pkg::S_LOAD);
  assign out_valid = (state == hcb_pkg::S_WK_OUT);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = HAW'(loaded);
    s_raddr = HAW'(k_node);
    h_we    = 1'b0;
    h_waddr = HAW'(idx);
    h_wdata = v;
    h_raddr = '0;
    c_we    = 1'b0;
    c_waddr = next_node;
    c_wdata = {a_ent[HEW-1 -: NW], top[HEW-1 -: NW]};
    c_raddr = k_node;
    k_we    = 1'b0;
    k_waddr = SAW'(sp);
    k_wdata = '0;
    k_raddr = SAW'(sp - SPW'(1));
    case (state)
      hcb_pkg::S_LOAD: begin
        if (in_valid && loaded < MAXI) begin
          s_we    = 1'b1;
          h_we    = 1'b1;
          h_waddr = HAW'(loaded);
          h_wdata = {NW'(loaded), freq_w};
        end
      end
      hcb_pkg::S_SD_LD: h_raddr = HAW'(idx);
      hcb_pkg::S_SD_L:  h_raddr = HAW'(lidx);
      hcb_pkg::S_SD_R:  h_raddr = HAW'(ridx);
      hcb_pkg::S_SD_DEC: begin
        h_we    = 1'b1;
        h_wdata = (best_i == idx) ? v : best_e;
      end
      hcb_pkg::S_TK1: h_raddr = HAW'(cnt - IW'(1));
      hcb_pkg::S_MK:  c_we = 1'b1;
      hcb_pkg::S_PU_CHK: begin
        h_raddr = HAW'(pidx);
        h_we    = (idx == '0);
      end
      hcb_pkg::S_PU_CMP: begin
        h_we    = 1'b1;
        h_wdata = (v[WW-1:0] < h_rdata[WW-1:0]) ? h_rdata : v;
      end
      hcb_pkg::S_ROOT: begin
        k_we    = 1'b1;
        k_waddr = '0;
        k_wdata = {h_rdata[HEW-1 -: NW], 31'd0, 6'd0};
      end
      hcb_pkg::S_WK_PR: begin
        k_we    = 1'b1;
        k_wdata = {c_rdata[NW-1:0], wcode[29:0], 1'b1, wlen + 6'd1};
      end
      hcb_pkg::S_WK_PL: begin
        k_we    = 1'b1;
        k_waddr = SAW'(sp + SPW'(1));
        k_wdata = {left_n, wcode[29:0], 1'b0, wlen + 6'd1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hcb_pkg::S_LOAD;
      phase   <= hcb_pkg::PH_HEAP;
      loaded  <= '0;
      dropped <= 1'b0;
      cnt     <= '0;
    end else begin
      case (state)
        hcb_pkg::S_LOAD: begin
          if (in_valid) begin
            loaded <= loaded_next;
            if (loaded == MAXI) begin
              dropped <= 1'b1;
            end
            if (final_symbol) begin
              n         <= loaded_next;
              cnt       <= loaded_next;
              idx       <= loaded_next >> 1;
              hidx      <= loaded_next >> 1;
              next_node <= NW'(loaded_next);
              emitted   <= '0;
              phase     <= hcb_pkg::PH_HEAP;
              state     <= hcb_pkg::S_SD_LD;
            end
          end
        end
        hcb_pkg::S_SD_LD: state <= hcb_pkg::S_SD_V;
        hcb_pkg::S_SD_V: begin
          v     <= h_rdata;
          state <= hcb_pkg::S_SD_L;
        end
        hcb_pkg::S_SD_L: begin
          if (lidx < cnt) begin
            state <= hcb_pkg::S_SD_R;
          end else begin
            best_i <= idx;
            state  <= hcb_pkg::S_SD_DEC;
          end
        end
        hcb_pkg::S_SD_R: begin
          if (h_rdata[WW-1:0] < v[WW-1:0]) begin
            best_i <= lidx;
            best_e <= h_rdata;
          end else begin
            best_i <= idx;
            best_e <= v;
          end
          state <= (ridx < cnt) ? hcb_pkg::S_SD_RC : hcb_pkg::S_SD_DEC;
        end
        hcb_pkg::S_SD_RC: begin
          if (h_rdata[WW-1:0] < best_e[WW-1:0]) begin
            best_i <= ridx;
            best_e <= h_rdata;
          end
          state <= hcb_pkg::S_SD_DEC;
        end
        hcb_pkg::S_SD_DEC: begin
          if (best_i != idx) begin
            idx   <= best_i;
            state <= hcb_pkg::S_SD_L;
          end else begin
            case (phase)
              hcb_pkg::PH_HEAP: begin
                if (hidx == '0) begin
                  state <= hcb_pkg::S_MRG;
                end else begin
                  hidx  <= hidx - IW'(1);
                  idx   <= hidx - IW'(1);
                  state <= hcb_pkg::S_SD_LD;
                end
              end
              hcb_pkg::PH_TA: begin
                a_ent <= top;
                phase <= hcb_pkg::PH_TB;
                state <= hcb_pkg::S_TK0;
              end
              default: state <= hcb_pkg::S_MK;
            endcase
          end
        end
        hcb_pkg::S_MRG: begin
          // read slot 0: either the next minimum or the finished root
          if (cnt != IW'(1)) begin
            phase <= hcb_pkg::PH_TA;
            state <= hcb_pkg::S_TK1;
          end else begin
            state <= hcb_pkg::S_ROOT;
          end
        end
        hcb_pkg::S_TK0: state <= hcb_pkg::S_TK1;
        hcb_pkg::S_TK1: begin
          top   <= h_rdata;
          state <= hcb_pkg::S_TK2;
        end
        hcb_pkg::S_TK2: begin
          v     <= h_rdata;
          cnt   <= cnt - IW'(1);
          idx   <= '0;
          state <= hcb_pkg::S_SD_L;
        end
        hcb_pkg::S_MK: begin
          v     <= {next_node, a_ent[WW-1:0] + top[WW-1:0]};
          idx   <= cnt;
          cnt   <= cnt + IW'(1);
          state <= hcb_pkg::S_PU_CHK;
        end
        hcb_pkg::S_PU_CHK: begin
          if (idx == '0) begin
            next_node <= next_node + NW'(1);
            state     <= hcb_pkg::S_MRG;
          end else begin
            state <= hcb_pkg::S_PU_CMP;
          end
        end
        hcb_pkg::S_PU_CMP: begin
          if (v[WW-1:0] < h_rdata[WW-1:0]) begin
            idx   <= pidx;
            state <= hcb_pkg::S_PU_CHK;
          end else begin
            next_node <= next_node + NW'(1);
            state     <= hcb_pkg::S_MRG;
          end
        end
        hcb_pkg::S_ROOT: begin
          cnt   <= '0;
          sp    <= SPW'(1);
          state <= hcb_pkg::S_WK_POP;
        end
        hcb_pkg::S_WK_POP: begin
          if (sp == '0) begin
            loaded  <= '0;
            dropped <= 1'b0;
            state   <= hcb_pkg::S_LOAD;
          end else begin
            sp    <= sp - SPW'(1);
            state <= hcb_pkg::S_WK_NODE;
          end
        end
        hcb_pkg::S_WK_NODE: begin
          wcode <= k_code;
          wlen  <= k_len;
          if (k_leaf) begin
            state <= hcb_pkg::S_WK_CAP;
          end else if (k_room) begin
            state <= hcb_pkg::S_WK_PR;
          end else begin
            // no stack room: drop this subtree
            state <= hcb_pkg::S_WK_POP;
          end
        end
        hcb_pkg::S_WK_CAP: begin
          coded_symbol  <= s_rdata;
          code_bits     <= wcode;
          code_length   <= wlen[4:0];
          overflow_flag <= dropped;
          last_code     <= (emitted + IW'(1)) == n;
          emitted       <= emitted + IW'(1);
          state         <= hcb_pkg::S_WK_OUT;
        end
        hcb_pkg::S_WK_OUT: begin
          if (out_ready) begin
            state <= hcb_pkg::S_WK_POP;
          end
        end
        hcb_pkg::S_WK_PR: begin
          left_n <= c_rdata[2*NW-1 -: NW];
          state  <= hcb_pkg::S_WK_PL;
        end
        hcb_pkg::S_WK_PL: begin
          sp    <= sp + SPW'(2);
          state <= hcb_pkg::S_WK_POP;
        end
        default: state <= hcb_pkg::S_LOAD;
      endcase
    end
  end

  hcb_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS), .AW(HAW)) u_sym_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(symbol),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  hcb_ram #(.WIDTH(HEW), .DEPTH(MAX_SYMBOLS), .AW(HAW)) u_heap_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  hcb_ram #(.WIDTH(2 * NW), .DEPTH(2 * MAX_SYMBOLS), .AW(NW)) u_child_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  hcb_ram #(.WIDTH(SEW), .DEPTH(MAX_SYMBOLS + 1), .AW(SAW)) u_stack_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

endmodule
